/* hdl/spa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Surface pool allocator package
// Request codes, fixed port widths and the config reset value used by the allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int CFG_W     = 6;
    localparam int PORT_SLOT_W = 5;
    localparam int CFG_RESET = 17;

    localparam logic REQ_GET     = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

endpackage
`default_nettype wire

/* hdl/spa_stamp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Surface pool allocator stamp memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_stamp_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hdl/surface_pool_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Surface pool allocator
// Hands out pool slots, first free slot else the one with the oldest stamp.
// ----------------------------------------------------------------------------
// A request is a transfer at a rising edge with start high and busy low.
// req_type selects get or release; slot_in names the slot to release.
// Each request produces one result on slot_out, evicted and error, marked
// by done for exactly one cycle; the receiver cannot stall it.
// A release is handled in the idle state: done follows the transfer edge and
// a new request may be taken while done is high.
// A get walks the slots one per cycle through a single stamp compare and
// the stamp memory read port. It stops at the first free slot; when all n
// slots are busy it passes through a drain state and picks the oldest stamp.
// The write state then registers the result; unwritten stamps read as zero.
// slots_in_use is written through cfg_we and cfg_wdata; the user must write
// it only while idle, which the block does not enforce. Reset clears all busy
// marks, stamp valid bits and the stamp counter; it sets slots_in_use to 17.
// ----------------------------------------------------------------------------
module surface_pool_allocator #(
    parameter int MAX_SLOTS  = 32,
    parameter int STAMP_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [spa_pkg::PORT_SLOT_W-1:0] slot_in,
    output logic                             done,
    output logic      [spa_pkg::PORT_SLOT_W-1:0] slot_out,
    output logic                             evicted,
    output logic                             error,
    input  wire logic                        cfg_we,
    input  wire logic [spa_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_RAW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (CNT_RAW > spa_pkg::CFG_W) ? CNT_RAW : spa_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [spa_pkg::CFG_W-1:0]    cfg_reg, cfg_next;
    logic [MAX_SLOTS-1:0]         busy_reg, busy_next;
    logic [MAX_SLOTS-1:0]         valid_reg, valid_next;
    logic [STAMP_BITS-1:0]        next_stamp_reg, next_stamp_next;
    logic                         done_reg, done_next;
    logic                         pend_reg, pend_next;

    logic [SLOT_W-1:0]            k_reg, k_next;
    logic [SLOT_W-1:0]            kd_reg, kd_next;
    logic [SLOT_W-1:0]            oldest_reg, oldest_next;
    logic [STAMP_BITS-1:0]        oldest_stamp_reg, oldest_stamp_next;
    logic [SLOT_W-1:0]            pick_reg, pick_next;
    logic                         evict_reg, evict_next;
    logic                         rd_valid_reg;
    logic [spa_pkg::PORT_SLOT_W-1:0] slot_out_reg, slot_out_next;
    logic                         evicted_reg, evicted_next;
    logic                         error_reg, error_next;

    logic [CW-1:0]                cfg_ext;
    logic [CW-1:0]                n_eff;
    logic                         last;
    logic [SLOT_W-1:0]            rel_idx;
    logic                         rel_ok;
    logic [STAMP_BITS-1:0]        ram_rdata;
    logic [STAMP_BITS-1:0]        stamp_rd;
    logic                         take;
    logic                         ram_we;

    assign cfg_ext = CW'(cfg_reg);
    assign n_eff   = (cfg_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) :
                     ((cfg_ext == '0) ? CW'(1) : cfg_ext);
    assign last    = (CW'(k_reg) + CW'(1)) == n_eff;
    assign rel_idx = SLOT_W'(slot_in);
    assign rel_ok  = (CW'(slot_in) < n_eff) && busy_reg[rel_idx];
    assign stamp_rd = rd_valid_reg ? ram_rdata : '0;
    assign take    = pend_reg && ((kd_reg == '0) || (stamp_rd < oldest_stamp_reg));
    assign ram_we  = (state_reg == ST_WRITE);

    spa_stamp_ram #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W (STAMP_BITS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pick_reg),
        .wdata (next_stamp_reg),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        cfg_next          = cfg_we ? cfg_wdata : cfg_reg;
        busy_next         = busy_reg;
        valid_next        = valid_reg;
        next_stamp_next   = next_stamp_reg;
        done_next         = 1'b0;
        pend_next         = pend_reg;
        k_next            = k_reg;
        kd_next           = kd_reg;
        oldest_next       = take ? kd_reg : oldest_reg;
        oldest_stamp_next = take ? stamp_rd : oldest_stamp_reg;
        pick_next         = pick_reg;
        evict_next        = evict_reg;
        slot_out_next     = slot_out_reg;
        evicted_next      = evicted_reg;
        error_next        = error_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == spa_pkg::REQ_GET)
                    begin
                        k_next     = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (rel_ok)
                        begin
                            busy_next[rel_idx] = 1'b0;
                        end
                        slot_out_next = slot_in;
                        evicted_next  = 1'b0;
                        error_next    = !rel_ok;
                        done_next     = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!busy_reg[k_reg])
                begin
                    pick_next  = k_reg;
                    evict_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    pend_next = 1'b1;
                    kd_next   = k_reg;
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + SLOT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                pick_next  = oldest_next;
                evict_next = 1'b1;
                pend_next  = 1'b0;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                busy_next[pick_reg]  = 1'b1;
                valid_next[pick_reg] = 1'b1;
                next_stamp_next      = next_stamp_reg + STAMP_BITS'(1);
                slot_out_next        = spa_pkg::PORT_SLOT_W'(pick_reg);
                evicted_next         = evict_reg;
                error_next           = 1'b0;
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= spa_pkg::CFG_W'(spa_pkg::CFG_RESET);
            busy_reg       <= '0;
            valid_reg      <= '0;
            next_stamp_reg <= '0;
            done_reg       <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            busy_reg       <= busy_next;
            valid_reg      <= valid_next;
            next_stamp_reg <= next_stamp_next;
            done_reg       <= done_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg            <= k_next;
        kd_reg           <= kd_next;
        oldest_reg       <= oldest_next;
        oldest_stamp_reg <= oldest_stamp_next;
        pick_reg         <= pick_next;
        evict_reg        <= evict_next;
        rd_valid_reg     <= valid_reg[k_reg];
        slot_out_reg     <= slot_out_next;
        evicted_reg      <= evicted_next;
        error_reg        <= error_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign slot_out = slot_out_reg;
    assign evicted  = evicted_reg;
    assign error    = error_reg;

    // A result never reports both an eviction and a release error.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(evicted && error))
        else $error("result flags both eviction and error");

    // An accepted release produces its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == spa_pkg::REQ_RELEASE)) |=> done)
        else $error("release result missing");

    // The granted slot is marked busy once a get completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (done && busy_reg[$past(pick_reg)]))
        else $error("granted slot not marked busy");

endmodule
`default_nettype wire
